@@ src/sca_pkg.sv @@
// shared types, operation codes and character maps for the scancode translator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package sca_pkg;

   localparam int RING_DEPTH_DEF = 16;
   localparam int OPQ_DEPTH      = 2;

   typedef logic [2:0] op_kind_type;

   localparam op_kind_type OP_NOP       = 3'd0;
   localparam op_kind_type OP_SHIFT_SET = 3'd1;
   localparam op_kind_type OP_SHIFT_CLR = 3'd2;
   localparam op_kind_type OP_PUSH      = 3'd3;
   localparam op_kind_type OP_READ      = 3'd4;

   localparam logic REQ_SCANCODE = 1'b0;
   localparam logic REQ_READ     = 1'b1;

   localparam logic [7:0] SC_LSHIFT     = 8'h2A;
   localparam logic [7:0] SC_RSHIFT     = 8'h36;
   localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;

   typedef struct packed {
      op_kind_type kind;
      logic [5:0]  code;
   } op_type;

   typedef logic [6:0] char_type;

   localparam char_type LOWER_MAP [64] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam char_type UPPER_MAP [64] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

endpackage

`default_nettype wire

@@ src/sca_front.sv @@
// front end: classifies an incoming transaction into a back-end operation
// depends on sca_pkg
`timescale 1ns / 1ps
`default_nettype none

module sca_front (
   input  wire logic        opcode,
   input  wire logic [7:0]  scancode,
   output sca_pkg::op_type  op
);
   import sca_pkg::*;

   always_comb begin
      op.code = scancode[5:0];
      if (opcode == REQ_READ) begin
         op.kind = OP_READ;
      end else if (scancode inside {SC_LSHIFT, SC_RSHIFT}) begin
         op.kind = OP_SHIFT_SET;
      end else if (scancode inside {SC_LSHIFT_REL, SC_RSHIFT_REL}) begin
         op.kind = OP_SHIFT_CLR;
      end else if (scancode[7] || scancode[6]) begin
         // other release codes and make codes with no character
         op.kind = OP_NOP;
      end else begin
         op.kind = OP_PUSH;
      end
   end

endmodule

`default_nettype wire

@@ src/sca_queue.sv @@
// short operation queue between front and back end
// depends on sca_pkg
`timescale 1ns / 1ps
`default_nettype none

module sca_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire sca_pkg::op_type op_in,
   output logic             full,
   output logic             valid,
   input  wire logic        pop,
   output sca_pkg::op_type  op_out
);
   import sca_pkg::*;

   localparam int PW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
   localparam int CW = $clog2(OPQ_DEPTH + 1);

   op_type         entry_ff [OPQ_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PW'(OPQ_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full   = (count_ff == CW'(OPQ_DEPTH));
   assign valid  = (count_ff != '0);
   assign op_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end
      if (pop && valid) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end
      if ((push && !full) && !(pop && valid)) begin
         count_in = count_ff + CW'(1);
      end else if (!(push && !full) && (pop && valid)) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

`default_nettype wire

@@ src/sca_back.sv @@
// back end: shift flag, character ring and result register
// depends on sca_pkg
`timescale 1ns / 1ps
`default_nettype none

module sca_back #(
   parameter int RING_DEPTH = sca_pkg::RING_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        op_valid,
   input  wire sca_pkg::op_type op,
   output logic             op_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_char_valid,
   output logic [6:0]       rsp_char_out,
   output logic             rsp_dropped,
   output logic             rsp_shift_active
);
   import sca_pkg::*;

   localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   char_type       ring_ff [RING_DEPTH];
   char_type       rd_data_ff;
   logic [PW-1:0]  wptr_ff, wptr_in;
   logic [PW-1:0]  rptr_ff, rptr_in;
   logic           shift_ff, shift_in;
   logic           state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           char_valid_ff, char_valid_in;
   char_type       char_out_ff, char_out_in;
   logic           dropped_ff, dropped_in;
   logic           shift_out_ff, shift_out_in;
   logic           load;
   logic           mem_we;
   logic           mem_re;
   logic           out_free;
   char_type       push_char;
   logic [PW-1:0]  wptr_next;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push_char = shift_ff ? UPPER_MAP[op.code] : LOWER_MAP[op.code];
   assign wptr_next = ptr_next(wptr_ff);

   always_comb begin
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      shift_in      = shift_ff;
      state_in      = state_ff;
      char_valid_in = 1'b0;
      char_out_in   = '0;
      dropped_in    = 1'b0;
      load          = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      op_pop        = 1'b0;
      case (state_ff)
         ST_READ: begin
            load          = 1'b1;
            char_valid_in = 1'b1;
            char_out_in   = rd_data_ff;
            state_in      = ST_IDLE;
         end
         ST_IDLE: begin
            if (op_valid && out_free) begin
               op_pop = 1'b1;
               load   = 1'b1;
               case (op.kind)
                  OP_SHIFT_SET: shift_in = 1'b1;
                  OP_SHIFT_CLR: shift_in = 1'b0;
                  OP_PUSH: begin
                     if (push_char != '0) begin
                        if (wptr_next == rptr_ff) begin
                           dropped_in = 1'b1;
                        end else begin
                           mem_we  = 1'b1;
                           wptr_in = wptr_next;
                        end
                     end
                  end
                  OP_READ: begin
                     if (rptr_ff != wptr_ff) begin
                        // result goes out after the registered ring read
                        load     = 1'b0;
                        mem_re   = 1'b1;
                        rptr_in  = ptr_next(rptr_ff);
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
      shift_out_in = shift_in;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         shift_ff     <= 1'b0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         shift_ff     <= shift_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_valid_ff <= char_valid_in;
         char_out_ff   <= char_out_in;
         dropped_ff    <= dropped_in;
         shift_out_ff  <= shift_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_ff[wptr_ff] <= push_char;
      end
      if (mem_re) begin
         rd_data_ff <= ring_ff[rptr_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_valid   = char_valid_ff;
   assign rsp_char_out     = char_out_ff;
   assign rsp_dropped      = dropped_ff;
   assign rsp_shift_active = shift_out_ff;

endmodule

`default_nettype wire

@@ src/scancode_to_ascii_fifo_core.sv @@
// top level of the set-1 scancode translator with character ring
// depends on sca_pkg, sca_front, sca_queue, sca_back
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   opcode, scancode
//   rsp_      out        rsp_valid/rsp_stall   char_valid, char_out, dropped, shift_active
//
// one transaction per cycle, while req_stall is low, into a two-entry operation queue; the back
// end retires one operation per cycle while rsp_stall does not hold the result register; a read
// that returns a character also passes a read state (the ring memory read port is registered)
// reset clears pointers, shift flag, queue and result valid flag; the ring and result payload are not cleared
// req_stall rises when the queue is full; rsp_stall holds the result register
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_fifo_core #(
   parameter int RING_DEPTH = sca_pkg::RING_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_scancode,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_char_valid,
   output logic [6:0]       rsp_char_out,
   output logic             rsp_dropped,
   output logic             rsp_shift_active
);
   import sca_pkg::*;

   op_type  front_op;
   op_type  back_op;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;

   sca_front u_front (
      .opcode   (req_opcode),
      .scancode (req_scancode),
      .op       (front_op)
   );

   sca_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_valid),
      .op_in  (front_op),
      .full   (q_full),
      .valid  (q_valid),
      .pop    (q_pop),
      .op_out (back_op)
   );

   sca_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (q_valid),
      .op               (back_op),
      .op_pop           (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_dropped      (rsp_dropped),
      .rsp_shift_active (rsp_shift_active)
   );

   assign req_stall = q_full;

endmodule

`default_nettype wire

@@ src/sca_checker.sv @@
// port-level checks for the scancode translator top level
// depends on scancode_to_ascii_fifo_core
`timescale 1ns / 1ps
`default_nettype none

module sca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_char_valid,
   input wire logic [6:0]  rsp_char_out,
   input wire logic        rsp_dropped
);

   // a stalled result transaction stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out)
         && $stable(rsp_char_valid) && $stable(rsp_dropped))
      else $error("rsp payload changed under stall");

   a_valid_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> !rsp_dropped)
      else $error("read result flagged as dropped");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_char_out == 7'd0)
      else $error("char_out nonzero without char_valid");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind scancode_to_ascii_fifo_core sca_checker u_sca_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_char_valid (rsp_char_valid),
   .rsp_char_out   (rsp_char_out),
   .rsp_dropped    (rsp_dropped)
);

`default_nettype wire
